FILE: rtl/core/tcal_pkg.sv
// ============================================================================
// tcal_pkg: shared types and constants of the touch sample calibrator
// Holds the controller states, the command group from the controller to the
// datapath and the fixed widths of the arithmetic.
// ============================================================================
package tcal_pkg;

    localparam int unsigned COORD_W = 12;
    localparam int unsigned PRESS_W = 16;
    localparam int unsigned COEF_W  = 19;
    localparam int unsigned OFFS_W  = 26;
    localparam int unsigned DIV_W   = 16;
    localparam int unsigned CFG_W   = 26;
    localparam int unsigned IDX_W   = 3;
    localparam int unsigned CNT_W   = 16;
    localparam int unsigned ACC_W   = 34;
    localparam int unsigned QUO_W   = 32;
    localparam int unsigned RX_W    = 24;
    localparam int unsigned STEP_W  = 6;

    localparam logic [STEP_W-1:0] PRESS_STEPS = 6'd24;
    localparam logic [STEP_W-1:0] AXIS_STEPS  = 6'd32;
    localparam logic [COORD_W-1:0] COORD_MAX  = 12'hFFF;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_X_RES    = 3'd0;
    localparam logic [IDX_W-1:0] REG_X_FROM_X = 3'd1;
    localparam logic [IDX_W-1:0] REG_X_FROM_Y = 3'd2;
    localparam logic [IDX_W-1:0] REG_X_OFFSET = 3'd3;
    localparam logic [IDX_W-1:0] REG_Y_FROM_X = 3'd4;
    localparam logic [IDX_W-1:0] REG_Y_FROM_Y = 3'd5;
    localparam logic [IDX_W-1:0] REG_Y_OFFSET = 3'd6;
    localparam logic [IDX_W-1:0] REG_DIVISOR  = 3'd7;

    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_TICK   = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_RX,
        S_MUL_RXZ,
        S_DIV_P_LOAD,
        S_DIV_P,
        S_SAVE_P,
        S_AXIS_A,
        S_AXIS_B,
        S_DIV_A_LOAD,
        S_DIV_A,
        S_SAVE_A,
        S_DONE
    } state_t;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_RX,
        MUL_RXZ,
        MUL_AXIS_A,
        MUL_AXIS_B
    } mul_op_t;

    typedef struct packed {
        logic    load_in;
        mul_op_t mul_op;
        logic    axis;
        logic    div_load_p;
        logic    div_load_a;
        logic    div_step;
        logic    save_p;
        logic    save_a;
        logic    out_load;
        logic    out_penup;
        logic    out_changed;
    } cmd_t;

endpackage

FILE: rtl/core/tcal_stream_if.sv
// ============================================================================
// tcal_stream_if: request channels of the touch sample calibrator
// Input channel carries one sample or tick request; output channel one event.
// ============================================================================
interface tcal_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [11:0] raw_x;
    logic [11:0] raw_y;
    logic [11:0] raw_z1;
    logic [11:0] raw_z2;

    modport source (output valid, action, raw_x, raw_y, raw_z1, raw_z2, input ready);
    modport sink   (input valid, action, raw_x, raw_y, raw_z1, raw_z2, output ready);
endinterface

interface tcal_out_if;
    logic        valid;
    logic        ready;
    logic        event_kind;
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic [15:0] pressure;
    logic        touch;
    logic        touch_changed;

    modport source (output valid, event_kind, pos_x, pos_y, pressure, touch, touch_changed,
                    input ready);
    modport sink   (input valid, event_kind, pos_x, pos_y, pressure, touch, touch_changed,
                    output ready);
endinterface

FILE: rtl/core/tcal_datapath.sv
// ============================================================================
// tcal_datapath: arithmetic of the touch sample calibrator
// Configuration registers, one shared multiplier, an accumulator, a serial
// restoring divider and the result register.
// ============================================================================
module tcal_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [tcal_pkg::IDX_W-1:0]    cfg_index,
    input  logic [tcal_pkg::CFG_W-1:0]    cfg_data,
    input  tcal_pkg::cmd_t                cmd,
    input  logic [tcal_pkg::COORD_W-1:0]  in_x,
    input  logic [tcal_pkg::COORD_W-1:0]  in_y,
    input  logic [tcal_pkg::COORD_W-1:0]  in_z1,
    input  logic [tcal_pkg::COORD_W-1:0]  in_z2,
    output logic                          event_kind,
    output logic [tcal_pkg::COORD_W-1:0]  pos_x,
    output logic [tcal_pkg::COORD_W-1:0]  pos_y,
    output logic [tcal_pkg::PRESS_W-1:0]  pressure,
    output logic                          touch,
    output logic                          touch_changed
);

    // configuration registers
    logic [11:0]                    xres_reg;
    logic signed [tcal_pkg::COEF_W-1:0] xfx_reg, xfy_reg, yfx_reg, yfy_reg;
    logic signed [tcal_pkg::OFFS_W-1:0] xoff_reg, yoff_reg;
    logic [tcal_pkg::DIV_W-1:0]     div_reg;

    // captured sample
    logic [tcal_pkg::COORD_W-1:0]   x_reg, yi_reg, z1_reg, z2_reg;

    // arithmetic state
    logic [tcal_pkg::RX_W-1:0]      rx_reg;
    logic [tcal_pkg::RX_W-1:0]      pn_reg;
    logic signed [tcal_pkg::ACC_W-1:0] acc_reg;
    logic [tcal_pkg::QUO_W-1:0]     num_reg, num_next;
    logic [tcal_pkg::DIV_W-1:0]     rem_reg, rem_next;
    logic [tcal_pkg::DIV_W-1:0]     den_reg;
    logic [tcal_pkg::PRESS_W-1:0]   press_reg, press_next;
    logic [tcal_pkg::COORD_W-1:0]   px_reg, py_reg, axis_val;

    // result register
    logic                           kind_reg, touch_reg, chg_reg;
    logic [tcal_pkg::COORD_W-1:0]   ox_reg, oy_reg;
    logic [tcal_pkg::PRESS_W-1:0]   op_reg;

    logic signed [24:0] mul_a;
    logic signed [19:0] mul_b;
    logic signed [44:0] prod;
    logic [tcal_pkg::DIV_W:0] rem_sh;
    logic               rem_ge;
    logic [tcal_pkg::RX_W-1:0] pdiff;

    // write configuration; a zero divisor is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xres_reg <= '0;
            xfx_reg  <= 19'sd4096;
            xfy_reg  <= '0;
            xoff_reg <= '0;
            yfx_reg  <= '0;
            yfy_reg  <= 19'sd4096;
            yoff_reg <= '0;
            div_reg  <= 16'd4096;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tcal_pkg::REG_X_RES:    xres_reg <= cfg_data[11:0];
                tcal_pkg::REG_X_FROM_X: xfx_reg  <= cfg_data[tcal_pkg::COEF_W-1:0];
                tcal_pkg::REG_X_FROM_Y: xfy_reg  <= cfg_data[tcal_pkg::COEF_W-1:0];
                tcal_pkg::REG_X_OFFSET: xoff_reg <= cfg_data[tcal_pkg::OFFS_W-1:0];
                tcal_pkg::REG_Y_FROM_X: yfx_reg  <= cfg_data[tcal_pkg::COEF_W-1:0];
                tcal_pkg::REG_Y_FROM_Y: yfy_reg  <= cfg_data[tcal_pkg::COEF_W-1:0];
                tcal_pkg::REG_Y_OFFSET: yoff_reg <= cfg_data[tcal_pkg::OFFS_W-1:0];
                tcal_pkg::REG_DIVISOR:
                begin
                    if (cfg_data[tcal_pkg::DIV_W-1:0] != '0)
                        div_reg <= cfg_data[tcal_pkg::DIV_W-1:0];
                end
                default: ;
            endcase
        end
    end

    // select multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.mul_op)
            tcal_pkg::MUL_RX:
            begin
                mul_a = {13'd0, x_reg};
                mul_b = {8'd0, xres_reg};
            end
            tcal_pkg::MUL_RXZ:
            begin
                mul_a = {1'b0, rx_reg};
                mul_b = {8'd0, z2_reg};
            end
            tcal_pkg::MUL_AXIS_A:
            begin
                mul_a = {13'd0, x_reg};
                mul_b = cmd.axis ? 20'(yfx_reg) : 20'(xfx_reg);
            end
            tcal_pkg::MUL_AXIS_B:
            begin
                mul_a = {13'd0, yi_reg};
                mul_b = cmd.axis ? 20'(yfy_reg) : 20'(xfy_reg);
            end
            default: ;
        endcase
    end

    assign prod = mul_a * mul_b;

    // one restoring division step
    always_comb
    begin
        rem_sh   = {rem_reg, num_reg[tcal_pkg::QUO_W-1]};
        rem_ge   = rem_sh >= {1'b0, den_reg};
        rem_next = rem_ge ? tcal_pkg::DIV_W'(rem_sh - {1'b0, den_reg})
                          : rem_sh[tcal_pkg::DIV_W-1:0];
        num_next = {num_reg[tcal_pkg::QUO_W-2:0], rem_ge};
    end

    // pressure from quotient minus R*x/4096, clamped and saturated
    always_comb
    begin
        pdiff = num_reg[tcal_pkg::RX_W-1:0] - {12'd0, rx_reg[23:12]};
        if (z1_reg == '0 || num_reg[tcal_pkg::RX_W-1:0] <= {12'd0, rx_reg[23:12]})
            press_next = '0;
        else if (pdiff[23:16] != '0)
            press_next = '1;
        else
            press_next = pdiff[15:0];
    end

    // clamp axis quotient; a negative sum always lands at zero
    always_comb
    begin
        if (acc_reg[tcal_pkg::ACC_W-1])
            axis_val = '0;
        else if (num_reg[tcal_pkg::QUO_W-1:tcal_pkg::COORD_W] != '0)
            axis_val = tcal_pkg::COORD_MAX;
        else
            axis_val = num_reg[tcal_pkg::COORD_W-1:0];
    end

    // advance the arithmetic
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            x_reg  <= in_x;
            yi_reg <= tcal_pkg::COORD_MAX - in_y;
            z1_reg <= in_z1;
            z2_reg <= in_z2;
        end
        unique case (cmd.mul_op)
            tcal_pkg::MUL_RX:     rx_reg  <= prod[tcal_pkg::RX_W-1:0];
            tcal_pkg::MUL_RXZ:    pn_reg  <= prod[35:12];
            tcal_pkg::MUL_AXIS_A: acc_reg <= (cmd.axis ? tcal_pkg::ACC_W'(yoff_reg)
                                                       : tcal_pkg::ACC_W'(xoff_reg))
                                             + prod[tcal_pkg::ACC_W-1:0];
            tcal_pkg::MUL_AXIS_B: acc_reg <= acc_reg + prod[tcal_pkg::ACC_W-1:0];
            default: ;
        endcase
        if (cmd.div_load_p)
        begin
            num_reg <= {pn_reg, 8'd0};
            rem_reg <= '0;
            den_reg <= {4'd0, z1_reg};
        end
        else if (cmd.div_load_a)
        begin
            num_reg <= acc_reg[tcal_pkg::QUO_W-1:0];
            rem_reg <= '0;
            den_reg <= div_reg;
        end
        else if (cmd.div_step)
        begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
        if (cmd.save_p)
            press_reg <= press_next;
        if (cmd.save_a)
        begin
            if (cmd.axis)
                py_reg <= axis_val;
            else
                px_reg <= axis_val;
        end
        if (cmd.out_load)
        begin
            kind_reg  <= cmd.out_penup;
            touch_reg <= !cmd.out_penup;
            chg_reg   <= cmd.out_changed;
            ox_reg    <= cmd.out_penup ? '0 : px_reg;
            oy_reg    <= cmd.out_penup ? '0 : py_reg;
            op_reg    <= cmd.out_penup ? '0 : press_reg;
        end
    end

    assign event_kind    = kind_reg;
    assign pos_x         = ox_reg;
    assign pos_y         = oy_reg;
    assign pressure      = op_reg;
    assign touch         = touch_reg;
    assign touch_changed = chg_reg;

endmodule

FILE: rtl/core/tcal_ctrl.sv
// ============================================================================
// tcal_ctrl: sequencer of the touch sample calibrator
// Steps the datapath through pressure and both axes, keeps the pen state and
// the pen-up countdown, and owns the request handshakes.
// ============================================================================
module tcal_ctrl #(
    parameter int unsigned PENUP_TICKS = 100
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           in_action,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    output tcal_pkg::cmd_t cmd
);

    tcal_pkg::state_t                state_reg, state_next;
    logic [tcal_pkg::STEP_W-1:0]     cnt_reg, cnt_next;
    logic [tcal_pkg::CNT_W-1:0]      down_reg, down_next;
    logic                            pen_reg, pen_next;
    logic                            axis_reg, axis_next;
    logic                            penup_reg, penup_next;
    logic                            chg_reg, chg_next;
    logic                            ovld_reg, ovld_next;
    logic                            accept;

    // hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tcal_pkg::S_IDLE;
            cnt_reg   <= '0;
            down_reg  <= '0;
            pen_reg   <= 1'b0;
            axis_reg  <= 1'b0;
            penup_reg <= 1'b0;
            chg_reg   <= 1'b0;
            ovld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            down_reg  <= down_next;
            pen_reg   <= pen_next;
            axis_reg  <= axis_next;
            penup_reg <= penup_next;
            chg_reg   <= chg_next;
            ovld_reg  <= ovld_next;
        end
    end

    assign in_ready  = (state_reg == tcal_pkg::S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = ovld_reg;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        down_next  = down_reg;
        pen_next   = pen_reg;
        axis_next  = axis_reg;
        penup_next = penup_reg;
        chg_next   = chg_reg;
        ovld_next  = ovld_reg && !out_ready;
        cmd        = '0;
        cmd.mul_op = tcal_pkg::MUL_NONE;
        cmd.axis   = axis_reg;
        cmd.out_penup   = penup_reg;
        cmd.out_changed = chg_reg;

        unique case (state_reg)
            tcal_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load_in = 1'b1;
                    if (in_action == tcal_pkg::ACT_SAMPLE)
                    begin
                        chg_next   = !pen_reg;
                        pen_next   = 1'b1;
                        down_next  = tcal_pkg::CNT_W'(PENUP_TICKS);
                        penup_next = 1'b0;
                        axis_next  = 1'b0;
                        state_next = tcal_pkg::S_MUL_RX;
                    end
                    else if (pen_reg)
                    begin
                        if (down_reg > tcal_pkg::CNT_W'(1))
                            down_next = down_reg - tcal_pkg::CNT_W'(1);
                        else
                        begin
                            down_next  = '0;
                            pen_next   = 1'b0;
                            penup_next = 1'b1;
                            chg_next   = 1'b1;
                            state_next = tcal_pkg::S_DONE;
                        end
                    end
                end
            end
            tcal_pkg::S_MUL_RX:
            begin
                cmd.mul_op = tcal_pkg::MUL_RX;
                state_next = tcal_pkg::S_MUL_RXZ;
            end
            tcal_pkg::S_MUL_RXZ:
            begin
                cmd.mul_op = tcal_pkg::MUL_RXZ;
                state_next = tcal_pkg::S_DIV_P_LOAD;
            end
            tcal_pkg::S_DIV_P_LOAD:
            begin
                cmd.div_load_p = 1'b1;
                cnt_next   = tcal_pkg::PRESS_STEPS;
                state_next = tcal_pkg::S_DIV_P;
            end
            tcal_pkg::S_DIV_P:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - tcal_pkg::STEP_W'(1);
                if (cnt_reg == tcal_pkg::STEP_W'(1))
                    state_next = tcal_pkg::S_SAVE_P;
            end
            tcal_pkg::S_SAVE_P:
            begin
                cmd.save_p = 1'b1;
                state_next = tcal_pkg::S_AXIS_A;
            end
            tcal_pkg::S_AXIS_A:
            begin
                cmd.mul_op = tcal_pkg::MUL_AXIS_A;
                state_next = tcal_pkg::S_AXIS_B;
            end
            tcal_pkg::S_AXIS_B:
            begin
                cmd.mul_op = tcal_pkg::MUL_AXIS_B;
                state_next = tcal_pkg::S_DIV_A_LOAD;
            end
            tcal_pkg::S_DIV_A_LOAD:
            begin
                cmd.div_load_a = 1'b1;
                cnt_next   = tcal_pkg::AXIS_STEPS;
                state_next = tcal_pkg::S_DIV_A;
            end
            tcal_pkg::S_DIV_A:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - tcal_pkg::STEP_W'(1);
                if (cnt_reg == tcal_pkg::STEP_W'(1))
                    state_next = tcal_pkg::S_SAVE_A;
            end
            tcal_pkg::S_SAVE_A:
            begin
                cmd.save_a = 1'b1;
                if (axis_reg)
                    state_next = tcal_pkg::S_DONE;
                else
                begin
                    axis_next  = 1'b1;
                    state_next = tcal_pkg::S_AXIS_A;
                end
            end
            tcal_pkg::S_DONE:
            begin
                // load the result register once it is free
                if (!ovld_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    ovld_next    = 1'b1;
                    state_next   = tcal_pkg::S_IDLE;
                end
            end
            default: state_next = tcal_pkg::S_IDLE;
        endcase
    end

endmodule

FILE: rtl/core/touch_sample_calibrator_unit.sv
// ============================================================================
// touch_sample_calibrator_unit: resistive touch pressure and calibration
// A sample runs a 24-step pressure divide and two 32-step axis divides on one
// serial divider; a tick gives a result only when the pen-up countdown ends.
// One request is in progress at a time; the result register frees the input
// side while a result waits. Reset restores default calibration,
// pen up, countdown zero, no pending result.
// ============================================================================
module touch_sample_calibrator_unit #(
    parameter int unsigned PENUP_TICKS = 100
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [tcal_pkg::IDX_W-1:0] cfg_index,
    input  logic [tcal_pkg::CFG_W-1:0] cfg_data,
    tcal_in_if.sink                    sample_in,
    tcal_out_if.source                 result_out
);

    tcal_pkg::cmd_t cmd;

    tcal_ctrl #(
        .PENUP_TICKS (PENUP_TICKS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample_in.valid),
        .in_action (sample_in.action),
        .in_ready  (sample_in.ready),
        .out_valid (result_out.valid),
        .out_ready (result_out.ready),
        .cmd       (cmd)
    );

    tcal_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cmd           (cmd),
        .in_x          (sample_in.raw_x),
        .in_y          (sample_in.raw_y),
        .in_z1         (sample_in.raw_z1),
        .in_z2         (sample_in.raw_z2),
        .event_kind    (result_out.event_kind),
        .pos_x         (result_out.pos_x),
        .pos_y         (result_out.pos_y),
        .pressure      (result_out.pressure),
        .touch         (result_out.touch),
        .touch_changed (result_out.touch_changed)
    );

endmodule
